>>> src/wpgc_pkg.sv
// Shared types and constants for the world point to grid cell unit.
package wpgc_pkg;

  localparam int unsigned PAT_W = 19;
  localparam int unsigned OUT_W = 25;
  localparam logic [16:0] TAN60_Q16 = 17'd113512;

  localparam logic [1:0] REG_TILE_SHAPE  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_HEX_H  = 2'd1,
    SHAPE_HEX_V  = 2'd2
  } shape_e;

  typedef struct packed {
    logic             vld;
    shape_e           shape;
    logic             neg_x;
    logic             neg_y;
    logic [PAT_W-1:0] px;
    logic [PAT_W-1:0] py;
  } side_t;

endpackage

>>> src/world_point_to_grid_cell_unit.sv
// Top level of the world point to grid cell unit: registers and pipeline.
// Usage
//   Input channel: pos_x_i/pos_y_i, signed world point, handshake on
//   in_valid_i/in_ready_o. Output channel: cell_row_o/cell_col_o, the
//   signed row and column of the tile holding the point, handshake on
//   out_valid_o/out_ready_i. One result item per input item, in order.
//   Configuration: cfg_we_i with cfg_addr_i (0 shape, 1 height, 2 width)
//   and cfg_wdata_i; write only while the pipeline is empty.
// Throughput and stages
//   One item per cycle while the receiver does not stall. The pipeline has 1
//   front stage, one stage per quotient bit of the restoring divider, which
//   is max(COORD_BITS + 2, 19) bits wide, then 4 back stages.
// Reset and stall
//   Reset clears every valid bit and loads shape square, height and width
//   200. When the receiver stalls, the whole pipeline holds; in_ready_o
//   drops only while a result sits at the output and is not taken, so no
//   item is lost or repeated.
module world_point_to_grid_cell_unit #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wpgc_pkg::OUT_W-1:0]   cell_row_o,
  output logic signed [wpgc_pkg::OUT_W-1:0]   cell_col_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_addr_i,
  input  logic [15:0]                         cfg_wdata_i
);

  // signed width of the offset point, and of the magnitude fed to the divider
  localparam int unsigned XW = ((COORD_BITS + 2 > wpgc_pkg::PAT_W) ?
                                COORD_BITS + 2 : wpgc_pkg::PAT_W) + 1;
  localparam int unsigned N  = XW - 1;

  logic [1:0]  shape_q;
  logic [15:0] height_q, width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= 2'd0;
      height_q <= 16'd200;
      width_q  <= 16'd200;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        wpgc_pkg::REG_TILE_SHAPE:  shape_q  <= cfg_wdata_i[1:0];
        wpgc_pkg::REG_TILE_HEIGHT: height_q <= cfg_wdata_i;
        wpgc_pkg::REG_TILE_WIDTH:  width_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // advance everything unless a finished result is held at the output
  logic en;
  logic out_vld;
  assign en          = !out_vld || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld;

  wpgc_pkg::side_t              side_f, side_d;
  logic [N-1:0]                 mx, my, qx, qy;
  logic [wpgc_pkg::PAT_W-1:0]   rx, ry;
  logic [wpgc_pkg::OUT_W-1:0]   row, col;

  wpgc_front #(.COORD_BITS(COORD_BITS), .XW(XW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .shape_i  (shape_q),
    .height_i (height_q),
    .width_i  (width_q),
    .side_o   (side_f),
    .mag_x_o  (mx),
    .mag_y_o  (my)
  );

  wpgc_divider #(.N(N)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_f),
    .mx_i   (mx),
    .my_i   (my),
    .side_o (side_d),
    .qx_o   (qx),
    .qy_o   (qy),
    .rx_o   (rx),
    .ry_o   (ry)
  );

  wpgc_hex #(.N(N)) u_hex (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_d),
    .qx_i   (qx),
    .qy_i   (qy),
    .rx_i   (rx),
    .ry_i   (ry),
    .vld_o  (out_vld),
    .row_o  (row),
    .col_o  (col)
  );

  assign cell_row_o = row;
  assign cell_col_o = col;

endmodule

>>> src/wpgc_front.sv
// Front stage: pattern sizes, half-pattern offset and sign folding.
module wpgc_front #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned XW = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic [1:0]                    shape_i,
  input  logic [15:0]                   height_i,
  input  logic [15:0]                   width_i,
  output wpgc_pkg::side_t               side_o,
  output logic [XW-2:0]                 mag_x_o,
  output logic [XW-2:0]                 mag_y_o
);

  wpgc_pkg::shape_e              shape;
  logic [15:0]                   h1, w1;
  logic [wpgc_pkg::PAT_W-1:0]    px, py;
  logic [XW-1:0]                 x, y;
  wpgc_pkg::side_t               side_d, side_q;
  logic [XW-2:0]                 mx_q, my_q;

  always_comb begin
    case (shape_i)
      wpgc_pkg::SHAPE_HEX_H: shape = wpgc_pkg::SHAPE_HEX_H;
      wpgc_pkg::SHAPE_HEX_V: shape = wpgc_pkg::SHAPE_HEX_V;
      default:               shape = wpgc_pkg::SHAPE_SQUARE;
    endcase
    h1 = (height_i == 16'd0) ? 16'd1 : height_i;
    w1 = (width_i == 16'd0) ? 16'd1 : width_i;
    px = {1'b0, h1, 2'b00} + ((shape == wpgc_pkg::SHAPE_HEX_V) ? {2'b00, h1, 1'b0} : '0);
    py = {1'b0, w1, 2'b00} + ((shape == wpgc_pkg::SHAPE_HEX_H) ? {2'b00, w1, 1'b0} : '0);
    x = {{(XW-COORD_BITS-2){pos_x_i[COORD_BITS-1]}}, pos_x_i, 2'b00}
        + {{(XW-wpgc_pkg::PAT_W+1){1'b0}}, px[wpgc_pkg::PAT_W-1:1]};
    y = {{(XW-COORD_BITS-2){pos_y_i[COORD_BITS-1]}}, pos_y_i, 2'b00}
        + {{(XW-wpgc_pkg::PAT_W+1){1'b0}}, py[wpgc_pkg::PAT_W-1:1]};
    side_d.vld   = vld_i;
    side_d.shape = shape;
    side_d.neg_x = x[XW-1];
    side_d.neg_y = y[XW-1];
    side_d.px    = px;
    side_d.py    = py;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  // negative side: divide ~x, then mirror quotient and remainder later
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= x[XW-1] ? ~x[XW-2:0] : x[XW-2:0];
      my_q <= y[XW-1] ? ~y[XW-2:0] : y[XW-2:0];
    end
  end

  assign side_o  = side_q;
  assign mag_x_o = mx_q;
  assign mag_y_o = my_q;

endmodule

>>> src/wpgc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, both axes in step.
module wpgc_divider #(
  parameter int unsigned N = 26
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  wpgc_pkg::side_t                side_i,
  input  logic [N-1:0]                   mx_i,
  input  logic [N-1:0]                   my_i,
  output wpgc_pkg::side_t                side_o,
  output logic [N-1:0]                   qx_o,
  output logic [N-1:0]                   qy_o,
  output logic [wpgc_pkg::PAT_W-1:0]     rx_o,
  output logic [wpgc_pkg::PAT_W-1:0]     ry_o
);

  localparam int unsigned PW = wpgc_pkg::PAT_W;

  wpgc_pkg::side_t side_q [N];
  logic [N-1:0]    mx_q [N];
  logic [N-1:0]    my_q [N];
  logic [N-1:0]    qx_q [N];
  logic [N-1:0]    qy_q [N];
  logic [PW-1:0]   rx_q [N];
  logic [PW-1:0]   ry_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    wpgc_pkg::side_t s_p;
    logic [N-1:0]    mx_p, my_p, qx_p, qy_p;
    logic [PW-1:0]   rx_p, ry_p;
    logic [PW:0]     tx, ty;
    logic            gx, gy;

    if (i == 0) begin : g_first
      assign s_p  = side_i;
      assign mx_p = mx_i;
      assign my_p = my_i;
      assign qx_p = '0;
      assign qy_p = '0;
      assign rx_p = '0;
      assign ry_p = '0;
    end else begin : g_next
      assign s_p  = side_q[i-1];
      assign mx_p = mx_q[i-1];
      assign my_p = my_q[i-1];
      assign qx_p = qx_q[i-1];
      assign qy_p = qy_q[i-1];
      assign rx_p = rx_q[i-1];
      assign ry_p = ry_q[i-1];
    end

    assign tx = {rx_p, mx_p[N-1-i]};
    assign ty = {ry_p, my_p[N-1-i]};
    assign gx = tx >= {1'b0, s_p.px};
    assign gy = ty >= {1'b0, s_p.py};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i] <= '0;
      end else if (en_i) begin
        side_q[i] <= s_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mx_q[i] <= mx_p;
        my_q[i] <= my_p;
        qx_q[i] <= {qx_p[N-2:0], gx};
        qy_q[i] <= {qy_p[N-2:0], gy};
        rx_q[i] <= gx ? PW'(tx - {1'b0, s_p.px}) : tx[PW-1:0];
        ry_q[i] <= gy ? PW'(ty - {1'b0, s_p.py}) : ty[PW-1:0];
      end
    end
  end

  assign side_o = side_q[N-1];
  assign qx_o   = qx_q[N-1];
  assign qy_o   = qy_q[N-1];
  assign rx_o   = rx_q[N-1];
  assign ry_o   = ry_q[N-1];

endmodule

>>> src/wpgc_hex.sv
// Back end: floor repair, centring, hexagon edge test and diagonal step.
module wpgc_hex #(
  parameter int unsigned N = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  wpgc_pkg::side_t               side_i,
  input  logic [N-1:0]                  qx_i,
  input  logic [N-1:0]                  qy_i,
  input  logic [wpgc_pkg::PAT_W-1:0]    rx_i,
  input  logic [wpgc_pkg::PAT_W-1:0]    ry_i,
  output logic                          vld_o,
  output logic [wpgc_pkg::OUT_W-1:0]    row_o,
  output logic [wpgc_pkg::OUT_W-1:0]    col_o
);

  localparam int unsigned PW = wpgc_pkg::PAT_W;
  localparam int unsigned RW = (N + 3 > wpgc_pkg::OUT_W) ? N + 3 : wpgc_pkg::OUT_W;

  // stage A: signed floor quotient and centred remainder
  logic              va_q;
  wpgc_pkg::shape_e  sha_q;
  logic [N:0]        qxa_q, qya_q;
  logic signed [PW:0] cxa_q, cya_q;
  logic [PW-1:0]     pxa_q, pya_q;
  logic [PW-1:0]     rrx, rry;

  always_comb begin
    rrx = side_i.neg_x ? PW'(side_i.px - PW'(1) - rx_i) : rx_i;
    rry = side_i.neg_y ? PW'(side_i.py - PW'(1) - ry_i) : ry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= side_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sha_q <= side_i.shape;
      qxa_q <= side_i.neg_x ? ~{1'b0, qx_i} : {1'b0, qx_i};
      qya_q <= side_i.neg_y ? ~{1'b0, qy_i} : {1'b0, qy_i};
      cxa_q <= $signed({1'b0, rrx}) - $signed({2'b00, side_i.px[PW-1:1]});
      cya_q <= $signed({1'b0, rry}) - $signed({2'b00, side_i.py[PW-1:1]});
      pxa_q <= side_i.px;
      pya_q <= side_i.py;
    end
  end

  // stage B: pick the tested axis, coarse bounds, edge distance
  logic [PW-1:0]     ax, ay, ta, tb, tpat;
  logic [PW+2:0]     a3, a6;
  logic              vb_q, hexb_q, nearb_q, farb_q;
  logic              xposb_q, xnegb_q, yposb_q, ynegb_q;
  logic [N:0]        qxb_q, qyb_q;
  logic [PW:0]       diffb_q;
  logic [PW-1:0]     bb_q;

  always_comb begin
    ax = cxa_q[PW] ? PW'(-cxa_q) : PW'(cxa_q);
    ay = cya_q[PW] ? PW'(-cya_q) : PW'(cya_q);
    if (sha_q == wpgc_pkg::SHAPE_HEX_H) begin
      ta = ay;  tb = ax;  tpat = pya_q;
    end else begin
      ta = ax;  tb = ay;  tpat = pxa_q;
    end
    a3 = {2'b00, ta, 1'b0} + {3'b000, ta};
    a6 = {1'b0, ta, 2'b00} + {2'b00, ta, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hexb_q  <= (sha_q == wpgc_pkg::SHAPE_HEX_H) || (sha_q == wpgc_pkg::SHAPE_HEX_V);
      nearb_q <= a6 >= {3'b000, tpat};
      farb_q  <= a3 > {3'b000, tpat};
      diffb_q <= (PW+1)'({3'b000, tpat} - a3);
      bb_q    <= tb;
      xposb_q <= !cxa_q[PW] && (cxa_q != '0);
      xnegb_q <= cxa_q[PW];
      yposb_q <= !cya_q[PW] && (cya_q != '0);
      ynegb_q <= cya_q[PW];
      qxb_q   <= qxa_q;
      qyb_q   <= qya_q;
    end
  end

  // stage C: slanted-edge products
  logic              vc_q, hexc_q, nearc_q, farc_q;
  logic              xposc_q, xnegc_q, yposc_q, ynegc_q;
  logic [N:0]        qxc_q, qyc_q;
  logic [PW+17:0]    lhsc_q, rhsc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hexc_q  <= hexb_q;
      nearc_q <= nearb_q;
      farc_q  <= farb_q;
      xposc_q <= xposb_q;
      xnegc_q <= xnegb_q;
      yposc_q <= yposb_q;
      ynegc_q <= ynegb_q;
      qxc_q   <= qxb_q;
      qyc_q   <= qyb_q;
      lhsc_q  <= {1'b0, bb_q, 17'd0} + {2'b00, bb_q, 16'd0};
      rhsc_q  <= {17'd0, diffb_q} * {{(PW+1){1'b0}}, wpgc_pkg::TAN60_Q16};
    end
  end

  // stage D: step decision and output register
  logic              step;
  logic [RW-1:0]     row_w, col_w;
  logic              vd_q;
  logic [wpgc_pkg::OUT_W-1:0] rowd_q, cold_q;

  always_comb begin
    step  = hexc_q && nearc_q && (farc_q || (lhsc_q > rhsc_q));
    row_w = {{(RW-N-1){qxc_q[N]}}, qxc_q};
    col_w = {{(RW-N-1){qyc_q[N]}}, qyc_q};
    if (hexc_q) begin
      row_w = {row_w[RW-2:0], 1'b0};
      col_w = {col_w[RW-2:0], 1'b0};
    end
    if (step && xposc_q) row_w = row_w + RW'(1);
    if (step && xnegc_q) row_w = row_w - RW'(1);
    if (step && yposc_q) col_w = col_w + RW'(1);
    if (step && ynegc_q) col_w = col_w - RW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rowd_q <= row_w[wpgc_pkg::OUT_W-1:0];
      cold_q <= col_w[wpgc_pkg::OUT_W-1:0];
    end
  end

  assign vld_o = vd_q;
  assign row_o = rowd_q;
  assign col_o = cold_q;

endmodule

>>> test/world_point_to_grid_cell_unit_tb.sv
// Testbench for the world point to grid cell unit: directed and random points.
module world_point_to_grid_cell_unit_tb;

  localparam int unsigned CB = 24;
  localparam int unsigned LIMIT = 600000;
  localparam int unsigned OW = wpgc_pkg::OUT_W;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic signed [CB-1:0]  pos_x_i;
  logic signed [CB-1:0]  pos_y_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [OW-1:0]  cell_row_o;
  logic signed [OW-1:0]  cell_col_o;
  logic                  cfg_we_i;
  logic [1:0]            cfg_addr_i;
  logic [15:0]           cfg_wdata_i;

  world_point_to_grid_cell_unit #(.COORD_BITS(CB)) dut (.*);

  typedef struct packed {
    logic [OW-1:0] row;
    logic [OW-1:0] col;
  } cell_t;

  // Tile mapping and store of expected cells
  class cell_board;
    logic [1:0]  shape;
    logic [15:0] height;
    logic [15:0] width;
    cell_t       pending[$];
    int          errors;

    function new();
      shape = wpgc_pkg::SHAPE_SQUARE; height = 16'd200; width = 16'd200; errors = 0;
    endfunction

    function longint fdiv(longint n, longint p, output longint r);
      longint q;
      q = n / p; r = n % p;
      if (r < 0) begin
        r += p; q -= 1;
      end
      return q;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // a along the tested axis, b across
    function bit off_hex(longint a, longint b, longint pat);
      if (3 * mag(a) > pat) return 1;
      return 64'sd196608 * mag(b) > longint'(wpgc_pkg::TAN60_Q16) * (pat - 3 * mag(a));
    endfunction

    function void note_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
      longint h, w, px, py, sx, sy, rx, ry, row, col, cx, cy;
      logic [1:0] s;
      cell_t c;
      h = (height == 0) ? 1 : height;
      w = (width == 0) ? 1 : width;
      s = (shape == 2'd3) ? wpgc_pkg::SHAPE_SQUARE : shape;
      px = (s == wpgc_pkg::SHAPE_HEX_V) ? 6 * h : 4 * h;
      py = (s == wpgc_pkg::SHAPE_HEX_H) ? 6 * w : 4 * w;
      sx = 4 * longint'(x) + px / 2;
      sy = 4 * longint'(y) + py / 2;
      row = fdiv(sx, px, rx);
      col = fdiv(sy, py, ry);
      cx = rx - px / 2;
      cy = ry - py / 2;
      if (s == wpgc_pkg::SHAPE_HEX_H) begin
        row *= 2; col *= 2;
        if (!(6 * mag(cy) < py) && off_hex(cy, cx, py)) begin
          row += sgn(cx); col += sgn(cy);
        end
      end else if (s == wpgc_pkg::SHAPE_HEX_V) begin
        row *= 2; col *= 2;
        if (!(6 * mag(cx) < px) && off_hex(cx, cy, px)) begin
          row += sgn(cx); col += sgn(cy);
        end
      end
      c.row = row[OW-1:0];
      c.col = col[OW-1:0];
      pending.push_back(c);
    endfunction

    function void check_cell(logic [OW-1:0] row, logic [OW-1:0] col);
      cell_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected cell row %0d col %0d", $time,
                 $signed(row), $signed(col));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.row !== row) begin
        $display("%0t: row expected %0d actual %0d", $time,
                 $signed(e.row), $signed(row));
        errors++;
      end
      if (e.col !== col) begin
        $display("%0t: col expected %0d actual %0d", $time,
                 $signed(e.col), $signed(col));
        errors++;
      end
    endfunction
  endclass

  cell_board board;
  int  cycles;
  bit  calm;      // no idling on either side
  bit  hold_off;  // receiver holds off for a long stretch

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("world_point_to_grid_cell_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver: idle at random unless calm or held off; check each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) board.check_cell(cell_row_o, cell_col_o);
      out_ready_i <= !hold_off && (calm || $urandom_range(99) >= 29);
    end
  end

  // Offer one point and hold it until taken; valid drops only when idling
  task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_point(x, y);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      wpgc_pkg::REG_TILE_SHAPE:  board.shape = val[1:0];
      wpgc_pkg::REG_TILE_HEIGHT: board.height = val;
      default:                   board.width = val;
    endcase
  endtask

  // Wait for the pipeline to drain before a register write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (CB + 12) @(posedge clk_i);
  endtask

  task automatic set_tiles(logic [1:0] s, logic [15:0] h, logic [15:0] w);
    drain();
    write_reg(wpgc_pkg::REG_TILE_SHAPE, {14'd0, s});
    write_reg(wpgc_pkg::REG_TILE_HEIGHT, h);
    write_reg(wpgc_pkg::REG_TILE_WIDTH, w);
    cfg_we_i <= 1'b0;
  endtask

  // Random point: mostly near tile boundaries, some full range
  task automatic random_point();
    logic signed [CB-1:0] x, y;
    int unsigned hh, ww;
    hh = (board.height == 0) ? 1 : board.height;
    ww = (board.width == 0) ? 1 : board.width;
    if ($urandom_range(3) == 0) begin
      x = CB'($urandom); y = CB'($urandom);
    end else begin
      x = CB'(int'($urandom_range(200)) - 100
              + int'(hh) * (int'($urandom_range(60)) - 30) / 2);
      y = CB'(int'($urandom_range(200)) - 100
              + int'(ww) * (int'($urandom_range(60)) - 30) / 2);
      if ($urandom_range(1)) begin
        x = CB'(int'($urandom_range(2 * hh)) - int'(hh));
        y = CB'(int'($urandom_range(2 * ww)) - int'(ww));
      end
    end
    send_point(x, y);
  endtask

  localparam logic signed [CB-1:0] XMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] XMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    logic [15:0] sizes[6];
    board = new();
    cycles = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = wpgc_pkg::REG_TILE_SHAPE;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset tiles, extremes, pattern boundaries either side of zero
    send_point(CB'(0), CB'(0));
    send_point(XMAX, XMIN);
    send_point(XMIN, XMAX);
    send_point(CB'(-100), CB'(-100));
    send_point(CB'(100), CB'(99));
    send_point(CB'(-101), CB'(300));
    foreach (sizes[i]) sizes[i] = 16'd0;
    set_tiles(wpgc_pkg::SHAPE_HEX_H, 16'd10, 16'd10);
    send_point(CB'(0), CB'(0));
    send_point(CB'(0), CB'(7));    // edge of the straight band
    send_point(CB'(0), CB'(-8));
    send_point(CB'(4), CB'(6));    // slanted edge corner regions
    send_point(CB'(-4), CB'(-6));
    send_point(CB'(4), CB'(-7));
    send_point(XMAX, XMAX);
    set_tiles(wpgc_pkg::SHAPE_HEX_V, 16'd10, 16'd10);
    send_point(CB'(7), CB'(0));
    send_point(CB'(-8), CB'(4));
    send_point(CB'(7), CB'(-4));
    send_point(XMIN, XMIN);
    set_tiles(2'd3, 16'd0, 16'd0);  // unused shape code and zero sizes
    send_point(CB'(-1), CB'(1));
    send_point(XMIN, XMAX);
    set_tiles(wpgc_pkg::SHAPE_HEX_H, 16'hFFFF, 16'hFFFF);
    send_point(XMAX, XMIN);
    send_point(CB'(-98304), CB'(98303));

    // Random phases across settings
    sizes = '{16'd1, 16'd2, 16'd7, 16'd200, 16'd1234, 16'hFFFF};
    for (int ph = 0; ph < 11; ph++) begin
      set_tiles(2'(ph % 3), sizes[$urandom_range(5)], sizes[$urandom_range(5)]);
      if ($urandom_range(2) == 0)
        set_tiles(2'(ph % 3), 16'($urandom), 16'($urandom));
      calm = (ph == 4);
      if (ph == 6) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (150) random_point();
    end
    calm = 1'b0;

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("world_point_to_grid_cell_unit_tb: done, clean");
    end else begin
      $display("world_point_to_grid_cell_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
